// ===== rtl/sct_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package sct_pkg;

  localparam int unsigned STAMP_W    = 32;
  localparam int unsigned ELAPSED_W  = 16;
  localparam int unsigned DUR_W      = 8;
  localparam int unsigned MINS_W     = 10;
  localparam int unsigned DIV_CNT_W  = $clog2(STAMP_W);

  localparam logic [STAMP_W-1:0]   MINUTE_RESET = 32'd60000000;
  localparam logic [ELAPSED_W-1:0] ELAPSED_MAX  = 16'hFFFF;
  localparam logic [MINS_W-1:0]    DURATION_MAX = 10'd255;

  localparam logic [1:0] REQ_ARM    = 2'd0;
  localparam logic [1:0] REQ_FEED   = 2'd1;
  localparam logic [1:0] REQ_DISARM = 2'd2;
  localparam logic [1:0] REQ_QUERY  = 2'd3;

  localparam logic [1:0] EV_NONE = 2'd0;
  localparam logic [1:0] EV_TICK = 2'd1;
  localparam logic [1:0] EV_FIRE = 2'd2;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic arm;
    logic clear;
    logic feed_add;
    logic div_init;
    logic div_step;
    logic minute_upd;
  } sct_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [1:0] req;
    logic       running;
    logic       accum_below;
  } sct_sts_t;

endpackage

`default_nettype wire

// ===== rtl/sct_dpath.sv =====
`timescale 1ns / 1ps
`default_nettype none

module sct_dpath
  import sct_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire sct_cmd_t             cmd,
  output sct_sts_t                  sts,
  input  wire logic [1:0]           req_type,
  input  wire logic [MINS_W-1:0]    minutes,
  input  wire logic [STAMP_W-1:0]   now_us,
  input  wire logic                 cfg_we,
  input  wire logic [STAMP_W-1:0]   cfg_data,
  output logic [1:0]                res_event,
  output logic                      res_armed,
  output logic [DUR_W-1:0]          res_total,
  output logic [DUR_W-1:0]          res_remaining
);

  logic [STAMP_W-1:0]   minute_len;
  logic [1:0]           req;
  logic [MINS_W-1:0]    mins;
  logic [STAMP_W-1:0]   now;

  logic                 running;
  logic [DUR_W-1:0]     duration_min;
  logic [ELAPSED_W-1:0] elapsed_count;
  logic [STAMP_W-1:0]   last_stamp;
  logic [STAMP_W-1:0]   tick_accum;
  logic [STAMP_W-1:0]   quo;
  logic [1:0]           event_q;

  logic [STAMP_W-1:0]   len_eff;
  logic [STAMP_W:0]     shifted;
  logic [STAMP_W:0]     trial;
  logic [ELAPSED_W:0]   el_sum;
  logic [ELAPSED_W-1:0] el_new;
  logic                 mins_ok;

  // a zero length counts as one tick
  assign len_eff = (minute_len == '0) ? {{(STAMP_W-1){1'b0}}, 1'b1} : minute_len;
  assign mins_ok = (mins != '0) && (mins <= DURATION_MAX);

  // restoring divider, tick_accum holds the partial remainder
  assign shifted = {tick_accum, quo[STAMP_W-1]};
  assign trial   = shifted - {1'b0, len_eff};

  assign el_sum = {1'b0, elapsed_count} + {1'b0, quo[ELAPSED_W-1:0]};
  assign el_new = ((|quo[STAMP_W-1:ELAPSED_W]) || el_sum[ELAPSED_W])
                  ? ELAPSED_MAX : el_sum[ELAPSED_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      minute_len <= MINUTE_RESET;
    end else if (cfg_we) begin
      minute_len <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req  <= req_type;
      mins <= minutes;
      now  <= now_us;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running       <= 1'b0;
      duration_min  <= '0;
      elapsed_count <= '0;
      last_stamp    <= '0;
      tick_accum    <= '0;
      event_q       <= EV_NONE;
    end else begin
      if (cmd.load) begin
        event_q <= EV_NONE;
      end
      if (cmd.clear || cmd.arm) begin
        if (cmd.arm && mins_ok) begin
          running      <= 1'b1;
          duration_min <= mins[DUR_W-1:0];
          last_stamp   <= now;
        end else begin
          running      <= 1'b0;
          duration_min <= '0;
          last_stamp   <= '0;
        end
        elapsed_count <= '0;
        tick_accum    <= '0;
      end
      if (cmd.feed_add) begin
        tick_accum <= tick_accum + (now - last_stamp);
        last_stamp <= now;
      end
      if (cmd.div_init) begin
        quo        <= tick_accum;
        tick_accum <= '0;
      end
      if (cmd.div_step) begin
        if (!trial[STAMP_W]) begin
          tick_accum <= trial[STAMP_W-1:0];
          quo        <= {quo[STAMP_W-2:0], 1'b1};
        end else begin
          tick_accum <= shifted[STAMP_W-1:0];
          quo        <= {quo[STAMP_W-2:0], 1'b0};
        end
      end
      if (cmd.minute_upd) begin
        if (el_new >= {{(ELAPSED_W-DUR_W){1'b0}}, duration_min}) begin
          running       <= 1'b0;
          duration_min  <= '0;
          elapsed_count <= '0;
          last_stamp    <= '0;
          tick_accum    <= '0;
          event_q       <= EV_FIRE;
        end else begin
          elapsed_count <= el_new;
          event_q       <= EV_TICK;
        end
      end
    end
  end

  always_comb begin
    sts.req         = req;
    sts.running     = running;
    sts.accum_below = tick_accum < len_eff;
  end

  assign res_event = event_q;
  assign res_armed = running;
  assign res_total = running ? duration_min : '0;
  assign res_remaining =
    (running && (elapsed_count < {{(ELAPSED_W-DUR_W){1'b0}}, duration_min}))
    ? (duration_min - elapsed_count[DUR_W-1:0]) : '0;

endmodule

`default_nettype wire

// ===== rtl/sct_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module sct_ctrl
  import sct_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire logic     out_free,
  output logic          out_load,
  input  wire sct_sts_t sts,
  output sct_cmd_t      cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_EXEC  = 3'd1;
  localparam logic [2:0] S_CHECK = 3'd2;
  localparam logic [2:0] S_DIV   = 3'd3;
  localparam logic [2:0] S_UPD   = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  logic [2:0]           state;
  logic [2:0]           state_next;
  logic [DIV_CNT_W-1:0] cnt;

  assign in_stall = (state != S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    out_load   = 1'b0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        state_next = S_DONE;
        case (sts.req)
          REQ_ARM:    cmd.arm = 1'b1;
          REQ_DISARM: cmd.clear = 1'b1;
          REQ_FEED: begin
            if (sts.running) begin
              cmd.feed_add = 1'b1;
              state_next   = S_CHECK;
            end
          end
          default: ;
        endcase
      end
      S_CHECK: begin
        if (sts.accum_below) begin
          state_next = S_DONE;
        end else begin
          cmd.div_init = 1'b1;
          state_next   = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (cnt == {DIV_CNT_W{1'b1}}) begin
          state_next = S_UPD;
        end
      end
      S_UPD: begin
        cmd.minute_upd = 1'b1;
        state_next     = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          out_load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      if (state == S_DIV) begin
        cnt <= cnt + 1'b1;
      end else begin
        cnt <= '0;
      end
    end
  end

  a_div_len: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV) && (cnt == {DIV_CNT_W{1'b1}}) |=> state == S_UPD)
    else $error("divider did not finish after full word");

  a_one_cmd: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.load, cmd.arm, cmd.clear, cmd.feed_add,
              cmd.div_init, cmd.div_step, cmd.minute_upd}))
    else $error("more than one datapath command");

  a_load_idle: assert property (@(posedge clk) disable iff (rst)
    out_load |=> (state == S_IDLE) && !in_stall)
    else $error("controller not back to idle after result");

endmodule

`default_nettype wire

// ===== rtl/sleep_countdown_timer.sv =====
`timescale 1ns / 1ps
`default_nettype none

// One-shot minute countdown fed with stamps of a free-running microsecond counter.
// Request channel: in_valid / in_stall carry req_type, minutes and now_us; a request
// is taken at an edge with in_valid high and in_stall low. Result channel:
// out_valid / out_stall carry event_res, armed, total_minutes and remaining_minutes,
// exactly one result per request.
// Configuration: cfg_valid / cfg_ready write minute_length_us; cfg_ready is always
// high. Write it only while no request is in flight.
// Arm, disarm, query and a feed while disarmed go straight from execution to the result;
// a feed while armed adds to the accumulator and checks it against a minute, and a feed
// that crosses a minute also runs the 32-step bit-serial divider and then updates the
// elapsed minutes. One request is in flight at a time; the next is taken only after the previous result is loaded.
// The result sits in an output register; the next request is taken while it waits,
// but a new result is held back until out_stall drops.
// Synchronous reset disarms the timer, clears the accumulator, empties the output
// register and restores minute_length_us to 60000000.

module sleep_countdown_timer
  import sct_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [1:0]         req_type,
  input  wire logic [MINS_W-1:0]  minutes,
  input  wire logic [STAMP_W-1:0] now_us,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [1:0]              event_res,
  output logic                    armed,
  output logic [DUR_W-1:0]        total_minutes,
  output logic [DUR_W-1:0]        remaining_minutes,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [STAMP_W-1:0] cfg_data
);

  sct_cmd_t         cmd;
  sct_sts_t         sts;
  logic             out_free;
  logic             out_load;
  logic [1:0]       res_event;
  logic             res_armed;
  logic [DUR_W-1:0] res_total;
  logic [DUR_W-1:0] res_remaining;

  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid || !out_stall;

  sct_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .out_free (out_free),
    .out_load (out_load),
    .sts      (sts),
    .cmd      (cmd)
  );

  sct_dpath u_dpath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sts           (sts),
    .req_type      (req_type),
    .minutes       (minutes),
    .now_us        (now_us),
    .cfg_we        (cfg_valid && cfg_ready),
    .cfg_data      (cfg_data),
    .res_event     (res_event),
    .res_armed     (res_armed),
    .res_total     (res_total),
    .res_remaining (res_remaining)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      event_res         <= res_event;
      armed             <= res_armed;
      total_minutes     <= res_total;
      remaining_minutes <= res_remaining;
    end
  end

  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("request taken while another is in flight");

  a_fire_disarms: assert property (@(posedge clk) disable iff (rst)
    out_valid && (event_res == EV_FIRE) |->
      !armed && (total_minutes == '0) && (remaining_minutes == '0))
    else $error("expiry result still armed");

  a_remaining: assert property (@(posedge clk) disable iff (rst)
    out_valid && armed |-> (total_minutes != '0) && (remaining_minutes <= total_minutes))
    else $error("remaining exceeds total");

endmodule

`default_nettype wire

// ===== test/sleep_timer_checker.sv =====
`timescale 1ns / 1ps

module sleep_timer_checker
  import sct_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  input  wire logic               in_stall,
  input  wire logic [1:0]         req_type,
  input  wire logic [MINS_W-1:0]  minutes,
  input  wire logic [STAMP_W-1:0] now_us,
  input  wire logic               out_valid,
  input  wire logic               out_stall,
  input  wire logic [1:0]         event_res,
  input  wire logic               armed,
  input  wire logic [DUR_W-1:0]   total_minutes,
  input  wire logic [DUR_W-1:0]   remaining_minutes,
  input  wire logic               cfg_valid,
  input  wire logic               cfg_ready,
  input  wire logic [STAMP_W-1:0] cfg_data,
  output int                      mismatches,
  output int                      awaited
);

  typedef struct packed {
    logic [1:0]       ev;
    logic             armed;
    logic [DUR_W-1:0] total;
    logic [DUR_W-1:0] remain;
  } timer_result_t;

  timer_result_t awaited_results[$];

  logic                 running;
  logic [DUR_W-1:0]     span;
  logic [ELAPSED_W-1:0] passed;
  logic [STAMP_W-1:0]   last_stamp;
  logic [STAMP_W-1:0]   accum;
  logic [STAMP_W-1:0]   minute_len;

  task automatic flag(input string what);
    mismatches++;
    if (mismatches <= 10) $display("%0t: %s", $time, what);
  endtask

  task automatic cmp_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (got !== want) flag($sformatf("%s: expected %0d, got %0d", name, want, got));
  endtask

  function automatic void disarm_timer();
    running    = 1'b0;
    span       = '0;
    passed     = '0;
    last_stamp = '0;
    accum      = '0;
  endfunction

  // applies one request to the timer copy and returns the result it should give
  function automatic timer_result_t advance_countdown(input logic [1:0] rq,
                                                      input logic [MINS_W-1:0] mn,
                                                      input logic [STAMP_W-1:0] nw);
    timer_result_t      r;
    logic [STAMP_W-1:0] len;
    logic [STAMP_W-1:0] whole;
    logic [STAMP_W:0]   sum;
    r.ev = EV_NONE;
    case (rq)
      REQ_ARM: begin
        disarm_timer();
        if (mn >= 1 && mn <= DURATION_MAX) begin
          running    = 1'b1;
          span       = mn[DUR_W-1:0];
          last_stamp = nw;
        end
      end
      REQ_FEED: begin
        if (running) begin
          accum      = accum + (nw - last_stamp);
          last_stamp = nw;
          // a zero length counts as one tick per minute
          len = (minute_len == '0) ? 32'd1 : minute_len;
          if (accum >= len) begin
            whole  = accum / len;
            accum  = accum % len;
            sum    = {1'b0, whole} + {{(STAMP_W-ELAPSED_W+1){1'b0}}, passed};
            passed = (sum > ELAPSED_MAX) ? ELAPSED_MAX : sum[ELAPSED_W-1:0];
            if (passed >= span) begin
              disarm_timer();
              r.ev = EV_FIRE;
            end else begin
              r.ev = EV_TICK;
            end
          end
        end
      end
      REQ_DISARM: disarm_timer();
      default: ;
    endcase
    r.armed  = running;
    r.total  = running ? span : '0;
    r.remain = (running && passed < span) ? span - passed[DUR_W-1:0] : '0;
    return r;
  endfunction

  always @(posedge clk) begin
    timer_result_t want;
    if (rst) begin
      disarm_timer();
      minute_len = MINUTE_RESET;
      mismatches = 0;
      awaited_results.delete();
    end else begin
      if (cfg_valid && cfg_ready) minute_len = cfg_data;
      if (out_valid && !out_stall) begin
        if (awaited_results.size() == 0) begin
          flag($sformatf("result with no request pending: event %0d armed %0d total %0d rem %0d",
                         event_res, armed, total_minutes, remaining_minutes));
        end else begin
          want = awaited_results.pop_front();
          cmp_field("event_res", 32'(want.ev), 32'(event_res));
          cmp_field("armed", 32'(want.armed), 32'(armed));
          cmp_field("total_minutes", 32'(want.total), 32'(total_minutes));
          cmp_field("remaining_minutes", 32'(want.remain), 32'(remaining_minutes));
        end
      end
      if (in_valid && !in_stall) awaited_results.push_back(advance_countdown(req_type, minutes, now_us));
    end
    awaited = awaited_results.size();
  end

endmodule

// ===== test/tb_sleep_countdown_timer.sv =====
`timescale 1ns / 1ps

module tb_sleep_countdown_timer;
  import sct_pkg::*;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [1:0]         req_type = REQ_QUERY;
  logic [MINS_W-1:0]  minutes = '0;
  logic [STAMP_W-1:0] now_us = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [1:0]         event_res;
  logic               armed;
  logic [DUR_W-1:0]   total_minutes;
  logic [DUR_W-1:0]   remaining_minutes;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [STAMP_W-1:0] cfg_data = '0;

  int mismatches;
  int awaited;

  logic               req_taken = 1'b0;
  logic               cfg_taken = 1'b0;
  int                 send_idle_pct = 0;
  int                 recv_idle_pct = 0;
  int                 hold_asks = 0;
  int                 hold_seen = 0;
  int                 hold_left = 0;
  logic [STAMP_W-1:0] cur_len = MINUTE_RESET;

  sleep_countdown_timer DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .req_type(req_type), .minutes(minutes), .now_us(now_us),
    .out_valid(out_valid), .out_stall(out_stall),
    .event_res(event_res), .armed(armed),
    .total_minutes(total_minutes), .remaining_minutes(remaining_minutes),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  sleep_timer_checker timer_check (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .req_type(req_type), .minutes(minutes), .now_us(now_us),
    .out_valid(out_valid), .out_stall(out_stall),
    .event_res(event_res), .armed(armed),
    .total_minutes(total_minutes), .remaining_minutes(remaining_minutes),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .mismatches(mismatches), .awaited(awaited)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    req_taken <= in_valid && !in_stall;
    cfg_taken <= cfg_valid && cfg_ready;
  end

  // result side: random stall, or a long counted hold-off when one is asked for
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left = hold_left - 1;
    end else if (hold_asks != hold_seen) begin
      hold_seen = hold_asks;
      hold_left = 300;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  initial begin
    #2_000_000;
    $display("tb_sleep_countdown_timer: errors");
    $finish;
  end

  // called at a falling edge, returns at the falling edge after the request is taken
  task automatic send_req(input logic [1:0] rq, input logic [MINS_W-1:0] mn,
                          input logic [STAMP_W-1:0] nw);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    req_type <= rq;
    minutes  <= mn;
    now_us   <= nw;
    do @(negedge clk); while (!req_taken);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (awaited != 0) @(negedge clk);
  endtask

  task automatic write_minute_len(input logic [STAMP_W-1:0] val);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_data  <= val;
    do @(negedge clk); while (!cfg_taken);
    cfg_valid <= 1'b0;
    cur_len = val;
  endtask

  // time step between feeds, scaled to the current minute length
  function automatic logic [STAMP_W-1:0] pick_step(input logic [STAMP_W-1:0] len);
    logic [63:0] l;
    logic [63:0] v;
    int unsigned k;
    l = (len == '0) ? 64'd1 : {32'd0, len};
    k = $urandom_range(99);
    if (k < 10) return '0;
    if (k < 20) return $urandom;
    if (k < 55) v = (l * $urandom_range(1000, 0)) / 1000;
    else v = (l * $urandom_range(3500, 1000)) / 1000;
    return v[STAMP_W-1:0];
  endfunction

  // mostly arm-then-feed sequences on a running clock, some random noise
  task automatic run_phase(input int n_items);
    int                 done;
    int                 k;
    int                 feeds;
    logic [MINS_W-1:0]  mn;
    logic [STAMP_W-1:0] clock_us;
    done = 0;
    clock_us = $urandom;
    while (done < n_items) begin
      if ($urandom_range(99) < 15) begin
        send_req(2'($urandom_range(3)), MINS_W'($urandom_range(1023)), $urandom);
        done++;
      end else begin
        k = $urandom_range(99);
        if (k < 70) mn = MINS_W'($urandom_range(6, 1));
        else if (k < 95) mn = MINS_W'($urandom_range(255, 1));
        else mn = DURATION_MAX;
        send_req(REQ_ARM, mn, clock_us);
        done++;
        feeds = $urandom_range(12, 1);
        repeat (feeds) begin
          if ($urandom_range(99) < 5)
            send_req(($urandom_range(1) != 0) ? REQ_QUERY : REQ_DISARM,
                     MINS_W'($urandom_range(1023)), clock_us);
          clock_us = clock_us + pick_step(cur_len);
          send_req(REQ_FEED, MINS_W'($urandom_range(1023)), clock_us);
          done++;
        end
      end
    end
  endtask

  initial begin
    logic [STAMP_W-1:0] phase_len [6];
    phase_len = '{32'd1, 32'hFFFF_FFFF, 32'd1000, MINUTE_RESET, 32'd0, 32'd37};
    phase_len[4] = $urandom_range(100000, 2);
    send_idle_pct = 7;
    recv_idle_pct = 49;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    send_req(REQ_QUERY, 10'd0, 32'd0);
    send_req(REQ_FEED, 10'd1023, 32'hFFFF_FFFF);  // feed while disarmed
    send_req(REQ_ARM, 10'd0, 32'd0);
    send_req(REQ_ARM, 10'd256, 32'd1);
    send_req(REQ_ARM, 10'd1023, 32'd2);
    send_req(REQ_ARM, 10'd255, 32'hFFFF_FFF0);
    send_req(REQ_FEED, 10'd0, 32'd59999983);      // stamp wraps, one tick short
    send_req(REQ_FEED, 10'd0, 32'd59999984);
    send_req(REQ_QUERY, 10'd0, 32'd0);
    send_req(REQ_FEED, 10'd0, 32'd239999989);
    send_req(REQ_DISARM, 10'd0, 32'd0);
    send_req(REQ_ARM, 10'd1, 32'd100);
    send_req(REQ_FEED, 10'd0, 32'd60000100);
    send_req(REQ_FEED, 10'd0, 32'd60000200);      // after expiry
    send_req(REQ_ARM, 10'd2, 32'd0);
    send_req(REQ_FEED, 10'd0, 32'hFFFF_FFFF);
    send_req(REQ_ARM, 10'd200, 32'd5);
    send_req(REQ_FEED, 10'd0, 32'd4);
    send_req(REQ_FEED, 10'd0, 32'd3);             // accumulator wraps
    send_req(REQ_ARM, 10'd0, 32'd7);
    write_minute_len(32'd0);
    send_req(REQ_ARM, 10'd255, 32'd0);
    send_req(REQ_FEED, 10'd0, 32'h8000_0000);     // elapsed saturates
    send_req(REQ_ARM, 10'd3, 32'd0);
    send_req(REQ_FEED, 10'd0, 32'd1);

    for (int ph = 0; ph < 6; ph++) begin
      if (ph < 2) begin
        send_idle_pct = 7;
        recv_idle_pct = 49;
      end else if (ph < 4) begin
        send_idle_pct = 49;
        recv_idle_pct = 7;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      write_minute_len(phase_len[ph]);
      if (ph == 1 || ph == 4) hold_asks++;
      run_phase(90);
    end

    wait_drained();
    repeat (50) @(negedge clk);
    if (mismatches == 0 && awaited == 0) begin
      $display("tb_sleep_countdown_timer: clean");
    end else begin
      $display("tb_sleep_countdown_timer: errors");
    end
    $finish;
  end

endmodule
